// ----- design/sbfr_pkg.sv -----
// Shared types, constants and frame byte tables for the bus frame responder.
// No dependencies.
package sbfr_pkg;

    localparam int         C_QUEUE_DEPTH = 4;

    localparam logic [7:0] C_TERM_BYTE   = 8'h0f;
    localparam logic [3:0] C_TYPE_INFO   = 4'd1;
    localparam logic [3:0] C_TYPE_POWER  = 4'd5;

    // header = frame type + ((data length - 1) << 4)
    localparam logic [7:0] C_INFO_HEADER = 8'h58;
    localparam logic [7:0] C_PWR_HEADER  = 8'h69;
    localparam logic [7:0] C_INFO_FIX_A  = 8'h80;
    localparam logic [7:0] C_INFO_FIX_B  = 8'h84;
    localparam logic [7:0] C_PWR_CSUM    = 8'h8c;

    localparam logic [3:0] C_INFO_LAST   = 4'd8;
    localparam logic [3:0] C_PWR_LAST    = 4'd9;

    typedef struct packed {
        logic       is_power;
        logic [7:0] j0;
        logic [7:0] j1;
        logic [7:0] j2;
        logic [7:0] j3;
        logic [6:0] sum7;
    } t_frame_desc;

    // 255 - s for s < 128
    function automatic logic [7:0] checksum(input logic [6:0] s);
        checksum = {1'b1, ~s};
    endfunction

    function automatic logic [3:0] last_index(input t_frame_desc d);
        last_index = d.is_power ? C_PWR_LAST : C_INFO_LAST;
    endfunction

    function automatic logic [7:0] frame_byte(input t_frame_desc d, input logic [3:0] idx);
        logic [7:0] b;
        b = C_TERM_BYTE;
        if (d.is_power) begin
            case (idx)
                4'd0:    b = C_PWR_HEADER;
                4'd1:    b = 8'h8a;
                4'd2:    b = 8'h89;
                4'd3:    b = 8'hde;
                4'd4:    b = 8'had;
                4'd5:    b = 8'hc5;
                4'd6:    b = 8'ha5;
                4'd7:    b = 8'h82;
                4'd8:    b = C_PWR_CSUM;
                default: b = C_TERM_BYTE;
            endcase
        end else begin
            case (idx)
                4'd0:    b = C_INFO_HEADER;
                4'd1:    b = d.j0;
                4'd2:    b = d.j1;
                4'd3:    b = C_INFO_FIX_A;
                4'd4:    b = d.j3;
                4'd5:    b = C_INFO_FIX_B;
                4'd6:    b = d.j2;
                4'd7:    b = checksum(d.sum7);
                default: b = C_TERM_BYTE;
            endcase
        end
        frame_byte = b;
    endfunction

endpackage

// ----- design/sbfr_front.sv -----
// Front end: takes input beats, tracks message heads and joystick bytes,
// and queues a frame descriptor at each answered terminator. Uses sbfr_pkg.
module sbfr_front
    import sbfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_joy_a,
    input  logic [7:0]  i_joy_b,
    input  logic [7:0]  i_joy_c,
    input  logic [7:0]  i_joy_d,
    input  logic        i_q_full,
    output logic        o_push,
    output t_frame_desc o_desc
);

    logic [7:0] r_j0, r_j1, r_j2, r_j3;
    logic [7:0] r_head;
    logic       r_in_msg;
    logic [7:0] n_head;
    logic       n_in_msg;
    logic       accept;
    logic       is_term;
    logic [3:0] msg_type;
    logic [8:0] gsum;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_term    = (i_rx_byte == C_TERM_BYTE);
    assign msg_type   = r_in_msg ? r_head[3:0] : i_rx_byte[3:0];

    // low 7 bits of header and data; fixed bytes 0x80 adds 0, 0x84 adds 4
    assign gsum = {2'b0, C_INFO_HEADER[6:0]} + {2'b0, r_j0[6:0]} + {2'b0, r_j1[6:0]}
                + {2'b0, r_j3[6:0]} + {2'b0, C_INFO_FIX_B[6:0]} + {2'b0, r_j2[6:0]};

    always_comb begin
        n_head   = r_head;
        n_in_msg = r_in_msg;
        if (accept && !i_cmd) begin
            if (!r_in_msg) begin
                n_head   = i_rx_byte;
                n_in_msg = 1'b1;
            end
            if (is_term) begin
                n_in_msg = 1'b0;
            end
        end
    end

    always_comb begin
        o_push = accept && !i_cmd && is_term
                 && (msg_type == C_TYPE_INFO || msg_type == C_TYPE_POWER);
        o_desc.is_power = (msg_type == C_TYPE_POWER);
        o_desc.j0       = r_j0;
        o_desc.j1       = r_j1;
        o_desc.j2       = r_j2;
        o_desc.j3       = r_j3;
        o_desc.sum7     = gsum[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j0     <= 8'hc0;
            r_j1     <= 8'hc0;
            r_j2     <= 8'hff;
            r_j3     <= 8'hc0;
            r_head   <= 8'h00;
            r_in_msg <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_in_msg <= n_in_msg;
            if (accept && i_cmd) begin
                r_j0 <= i_joy_a;
                r_j1 <= i_joy_b;
                r_j2 <= i_joy_c;
                r_j3 <= i_joy_d;
            end
        end
    end

endmodule

// ----- design/sbfr_queue.sv -----
// Descriptor queue between front and back ends. Uses sbfr_pkg.
// Head entry is registered, read ahead at the next read pointer; pop advances it.
module sbfr_queue
    import sbfr_pkg::*;
#(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_desc i_desc,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_valid,
    output t_frame_desc o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame_desc     r_mem [DEPTH];
    t_frame_desc     r_head;
    logic [PW-1:0]   r_wr, r_rd;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   r_count;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_head;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_rd = r_rd;
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
    end

    // write-through when the entry going to the head is written this cycle
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
        if (i_push && (r_wr == n_rd)) begin
            r_head <= i_desc;
        end else begin
            r_head <= r_mem[n_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            r_rd    <= n_rd;
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !do_pop))
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count past depth");

endmodule

// ----- design/sbfr_back.sv -----
// Back end: walks the head descriptor byte by byte into an output register.
// Uses sbfr_pkg.
module sbfr_back
    import sbfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_frame_desc i_desc,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_frame_end
);

    logic [3:0] r_idx;
    logic [3:0] n_idx;
    logic       r_valid;
    logic [7:0] r_tx;
    logic       r_end;
    logic       load;
    logic       is_last;

    assign load    = i_q_valid && (!r_valid || i_out_ready);
    assign is_last = (r_idx == last_index(i_desc));
    assign o_pop   = load && is_last;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = is_last ? 4'd0 : r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx  <= frame_byte(i_desc, r_idx);
            r_end <= is_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_tx_byte   = r_tx;
    assign o_frame_end = r_end;

    a_end_is_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_end |-> r_tx == C_TERM_BYTE)
        else $error("frame end on non-terminator beat");

    a_mid_frame_has_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 4'd0 |-> i_q_valid)
        else $error("frame in progress without descriptor");

endmodule

// ----- design/serial_bus_frame_responder.sv -----
// Bus frame responder: input bytes and joystick updates in, response frames out.
// Depends on sbfr_pkg, sbfr_front, sbfr_queue, sbfr_back.
//
// One input beat is taken per cycle while the descriptor queue has room; a
// terminator that closes a type 1 or type 5 message queues one frame, which
// the back end sends at one byte per cycle while i_out_ready is high (9 bytes
// for general info, 10 for power up), the last flagged by o_frame_end. Input
// stalls only when QUEUE_DEPTH frames wait behind the output; the output register
// lets the front keep taking beats while a result byte waits.
module serial_bus_frame_responder
    import sbfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_joy_a,
    input  logic [7:0] i_joy_b,
    input  logic [7:0] i_joy_c,
    input  logic [7:0] i_joy_d,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_frame_end
);

    logic        push, pop, q_full, q_valid;
    t_frame_desc push_desc, head_desc;

    sbfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_rx_byte  (i_rx_byte),
        .i_joy_a    (i_joy_a),
        .i_joy_b    (i_joy_b),
        .i_joy_c    (i_joy_c),
        .i_joy_d    (i_joy_d),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_desc     (push_desc)
    );

    sbfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head_desc)
    );

    sbfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_desc      (head_desc),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

// ----- verif/serial_bus_frame_responder_test.sv -----
// Self-checking testbench for serial_bus_frame_responder: directed and random bus bytes
// and joystick updates, response frames predicted in-bench and checked beat by beat.
// Depends on sbfr_pkg and the serial_bus_frame_responder RTL.
module serial_bus_frame_responder_test
    import sbfr_pkg::*;
();

    localparam logic       CMD_BUS_BYTE = 1'b0;
    localparam logic       CMD_JOYSTICK = 1'b1;
    localparam logic [3:0] INFO_FRAME   = 4'd8;
    localparam logic [3:0] POWER_FRAME  = 4'd9;
    localparam int         PHASE_ITEMS  = 120;
    localparam int         STALL_LIMIT  = 2000;

    typedef struct {
        logic       cmd;
        logic [7:0] rx;
        logic [7:0] ja;
        logic [7:0] jb;
        logic [7:0] jc;
        logic [7:0] jd;
    } t_in_beat;

    typedef struct {
        logic [7:0] tx;
        logic       fend;
    } t_tx_beat;

    typedef logic [7:0] t_body [7];

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_cmd = 1'b0;
    logic [7:0] in_rx = 8'h00;
    logic [7:0] in_ja = 8'h00;
    logic [7:0] in_jb = 8'h00;
    logic [7:0] in_jc = 8'h00;
    logic [7:0] in_jd = 8'h00;
    logic       out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_tx_byte;
    logic       o_frame_end;

    t_in_beat   pending_beats [$];
    t_in_beat   cur_beat;
    t_tx_beat   frame_bytes [$];

    // predictor state
    logic [7:0] joy_state [4] = '{8'hc0, 8'hc0, 8'hff, 8'hc0};
    logic [7:0] head_state = 8'h00;
    logic       in_msg = 1'b0;

    int send_idle_pct = 33;
    int recv_idle_pct = 48;
    int items_queued = 0;
    int beats_in = 0;
    int joy_updates = 0;
    int bytes_out = 0;
    int frames_out = 0;
    int err_count = 0;
    int stall_cycles = 0;

    serial_bus_frame_responder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (in_cmd),
        .i_rx_byte   (in_rx),
        .i_joy_a     (in_ja),
        .i_joy_b     (in_jb),
        .i_joy_c     (in_jc),
        .i_joy_d     (in_jd),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic queue_frame(input logic [3:0] ftype, input t_body body, input int len);
        logic [7:0] hdr;
        int         sum;
        hdr = {4'(len - 1), ftype};
        sum = hdr & 8'h7f;
        frame_bytes.push_back(t_tx_beat'{hdr, 1'b0});
        for (int k = 0; k < len; k++) begin
            sum += body[k] & 8'h7f;
            frame_bytes.push_back(t_tx_beat'{body[k], 1'b0});
        end
        frame_bytes.push_back(t_tx_beat'{8'(255 - (sum % 128)), 1'b0});
        frame_bytes.push_back(t_tx_beat'{C_TERM_BYTE, 1'b1});
    endtask

    task automatic predict_response(input t_in_beat it);
        t_body body;
        if (it.cmd == CMD_JOYSTICK) begin
            joy_state[0] = it.ja;
            joy_state[1] = it.jb;
            joy_state[2] = it.jc;
            joy_state[3] = it.jd;
        end else begin
            if (!in_msg) begin
                head_state = it.rx;
                in_msg = 1'b1;
            end
            if (it.rx == C_TERM_BYTE) begin
                in_msg = 1'b0;
                if (head_state[3:0] == C_TYPE_INFO) begin
                    body = '{joy_state[0], joy_state[1], 8'h80, joy_state[3], 8'h84,
                             joy_state[2], 8'h00};
                    queue_frame(INFO_FRAME, body, 6);
                end else if (head_state[3:0] == C_TYPE_POWER) begin
                    body = '{8'h8a, 8'h89, 8'hde, 8'had, 8'hc5, 8'ha5, 8'h82};
                    queue_frame(POWER_FRAME, body, 7);
                end
            end
        end
    endtask

    task automatic push_bus_byte(input logic [7:0] b);
        t_in_beat it;
        it.cmd = CMD_BUS_BYTE;
        it.rx  = b;
        it.ja  = 8'($urandom);
        it.jb  = 8'($urandom);
        it.jc  = 8'($urandom);
        it.jd  = 8'($urandom);
        pending_beats.push_back(it);
        items_queued++;
    endtask

    task automatic push_joystick(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c, input logic [7:0] d);
        t_in_beat it;
        it.cmd = CMD_JOYSTICK;
        it.rx  = 8'($urandom);
        it.ja  = a;
        it.jb  = b;
        it.jc  = c;
        it.jd  = d;
        pending_beats.push_back(it);
        items_queued++;
    endtask

    task automatic push_random_joystick();
        push_joystick(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic push_message(input logic [7:0] head, input int body_len);
        logic [7:0] b;
        push_bus_byte(head);
        if (head != C_TERM_BYTE) begin
            for (int k = 0; k < body_len; k++) begin
                if ($urandom_range(7) == 0) begin
                    push_random_joystick();
                end else begin
                    do b = 8'($urandom_range(255)); while (b == C_TERM_BYTE);
                    push_bus_byte(b);
                end
            end
            push_bus_byte(C_TERM_BYTE);
        end
    endtask

    task automatic push_random_item();
        int         roll;
        logic [3:0] typ;
        int         len;
        roll = $urandom_range(99);
        if (roll < 10) begin
            push_random_joystick();
        end else if (roll < 15) begin
            push_bus_byte(8'($urandom_range(255)));
        end else begin
            if (roll < 55)
                typ = C_TYPE_INFO;
            else if (roll < 85)
                typ = C_TYPE_POWER;
            else
                typ = 4'($urandom_range(15));
            len = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
            push_message({4'($urandom_range(15)), typ}, len);
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || frame_bytes.size() != 0)
            @(negedge clk);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_response(cur_beat);
                beats_in++;
                if (cur_beat.cmd == CMD_JOYSTICK)
                    joy_updates++;
            end
            if (!(in_valid && !o_in_ready)) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    in_cmd   <= cur_beat.cmd;
                    in_rx    <= cur_beat.rx;
                    in_ja    <= cur_beat.ja;
                    in_jb    <= cur_beat.jb;
                    in_jc    <= cur_beat.jc;
                    in_jd    <= cur_beat.jd;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_tx_beat want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                bytes_out++;
                if (o_frame_end)
                    frames_out++;
                if (frame_bytes.size() == 0) begin
                    $error("tx_byte %h arrived with no response byte pending", o_tx_byte);
                    err_count++;
                end else begin
                    want = frame_bytes.pop_front();
                    if (o_tx_byte !== want.tx) begin
                        $error("tx_byte: expected %h, got %h", want.tx, o_tx_byte);
                        err_count++;
                    end
                    if (o_frame_end !== want.fend) begin
                        $error("frame_end: expected %b, got %b", want.fend, o_frame_end);
                        err_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles without any beat on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("serial_bus_frame_responder: mismatch");
        $finish;
    end

    initial begin
        int target;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        push_message(8'h01, 0);
        push_joystick(8'h00, 8'h00, 8'h00, 8'h00);
        push_message(8'h01, 0);
        push_joystick(8'hff, 8'hff, 8'hff, 8'hff);
        push_message(8'hf1, 1);
        push_message(8'h05, 0);
        push_bus_byte(C_TERM_BYTE);
        push_message(8'h02, 0);
        push_message(8'hff, 0);
        push_bus_byte(8'h81);
        push_bus_byte(8'hff);
        push_bus_byte(8'h00);
        push_joystick(8'h12, 8'h34, 8'h56, 8'h78);
        push_bus_byte(C_TERM_BYTE);
        push_message(8'h75, 1);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 48;
                recv_idle_pct = 33;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target)
                push_random_item();
            // sender holds off until every response byte is out
            wait_drained();
        end

        repeat (20) @(negedge clk);
        $display("%0d input beats taken, %0d of them joystick updates", beats_in, joy_updates);
        $display("%0d response bytes checked in %0d frames", bytes_out, frames_out);
        if (err_count == 0)
            $display("serial_bus_frame_responder: match");
        else
            $display("serial_bus_frame_responder: mismatch");
        $finish;
    end

endmodule
